// ----- rtl/text_console_cursor_writer_core_assert.svh -----
// assertion macros used by the console cursor writer engine
`ifndef TEXT_CONSOLE_CURSOR_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle as the trigger
`define TCCW_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// condition holds in the cycle after the trigger
`define TCCW_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`else

`define TCCW_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define TCCW_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ----- rtl/tccw_pkg.sv -----
// shared types and constants of the console cursor writer
package tccw_pkg;

    typedef enum logic {
        REQ_CHAR    = 1'b0,
        REQ_SET_POS = 1'b1
    } t_req_type;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

endpackage

// ----- rtl/tccw_if.sv -----
// channel interfaces: request, result and attribute write
interface tccw_req_if #(
    parameter int ROW_W = 5,
    parameter int COL_W = 7
);
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] row_number;
    logic [COL_W-1:0] column_number;

    modport source (output valid, req_type, char_code, row_number, column_number,
                    input ready);
    modport sink   (input valid, req_type, char_code, row_number, column_number,
                    output ready);
endinterface

interface tccw_res_if #(
    parameter int CELL_W = 11,
    parameter int RIDX_W = 5
);
    logic              valid;
    logic              ready;
    logic              cell_write;
    logic [CELL_W-1:0] cell_index;
    logic [15:0]       cell_data;
    logic              clear_row;
    logic [RIDX_W-1:0] clear_row_index;
    logic [CELL_W-1:0] cursor_after;

    modport source (output valid, cell_write, cell_index, cell_data, clear_row,
                    clear_row_index, cursor_after, input ready);
    modport sink   (input valid, cell_write, cell_index, cell_data, clear_row,
                    clear_row_index, cursor_after, output ready);
endinterface

interface tccw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/tccw_in_stage.sv -----
// input register stage for request items
module tccw_in_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccw_req_if.sink    i_req,
    tccw_req_if.source  o_req
);
    logic r_valid;
    logic w_take;

    assign i_req.ready = !r_valid || o_req.ready;
    assign w_take      = i_req.valid && i_req.ready;
    assign o_req.valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_req.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_req.req_type      <= i_req.req_type;
            o_req.char_code     <= i_req.char_code;
            o_req.row_number    <= i_req.row_number;
            o_req.column_number <= i_req.column_number;
        end
    end
endmodule

// ----- rtl/tccw_engine.sv -----
// cursor state, per-item update logic and result register
`include "text_console_cursor_writer_core_assert.svh"

module tccw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ROW_W   = 5,
    parameter int COL_W   = 7,
    parameter int CELL_W  = 11,
    parameter int RIDX_W  = 5,
    parameter int CIDX_W  = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_text_attribute,
    tccw_req_if.sink    i_req,
    tccw_res_if.source  o_res
);
    import tccw_pkg::*;

    localparam logic [ROW_W-1:0]  END_ROW  = ROW_W'(ROWS);
    localparam logic [CELL_W-1:0] END_CELL = CELL_W'(ROWS * COLUMNS);

    // cursor kept as row, column and cell index together
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [CIDX_W-1:0] r_col,  n_col;
    logic [CELL_W-1:0] r_cell, n_cell;

    logic              r_res_valid;
    logic              r_cell_write,  n_cell_write;
    logic [CELL_W-1:0] r_cell_index,  n_cell_index;
    logic [15:0]       r_cell_data,   n_cell_data;
    logic              r_clear_row,   n_clear_row;
    logic [RIDX_W-1:0] r_clear_idx,   n_clear_idx;

    logic              w_advance;
    logic              w_at_end;
    logic [ROW_W-1:0]  w_row;
    logic [CIDX_W-1:0] w_col;
    logic [CELL_W-1:0] w_cell;
    logic [RIDX_W-1:0] w_set_row;
    logic [CIDX_W-1:0] w_set_col;

    assign i_req.ready = !r_res_valid || o_res.ready;
    assign w_advance   = i_req.valid && i_req.ready;

    // end of screen wraps home before a character
    assign w_at_end = (r_row == END_ROW);
    assign w_row    = w_at_end ? '0 : r_row;
    assign w_col    = w_at_end ? '0 : r_col;
    assign w_cell   = w_at_end ? '0 : r_cell;

    // clamp the 1-based position into the grid
    always_comb begin
        if (i_req.row_number == '0) begin
            w_set_row = '0;
        end else if (i_req.row_number > END_ROW) begin
            w_set_row = RIDX_W'(ROWS - 1);
        end else begin
            w_set_row = RIDX_W'(i_req.row_number - 1'b1);
        end
        if (i_req.column_number == '0) begin
            w_set_col = '0;
        end else if (i_req.column_number > COL_W'(COLUMNS)) begin
            w_set_col = CIDX_W'(COLUMNS - 1);
        end else begin
            w_set_col = CIDX_W'(i_req.column_number - 1'b1);
        end
    end

    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_cell       = r_cell;
        n_cell_write = 1'b0;
        n_cell_index = '0;
        n_cell_data  = '0;
        n_clear_row  = 1'b0;
        n_clear_idx  = '0;
        case (t_req_type'(i_req.req_type))
            REQ_SET_POS: begin
                n_row  = ROW_W'(w_set_row);
                n_col  = w_set_col;
                n_cell = CELL_W'(w_set_row) * CELL_W'(COLUMNS) + CELL_W'(w_set_col);
            end
            REQ_CHAR: begin
                if (w_col == '0) begin
                    n_clear_row = 1'b1;
                    n_clear_idx = w_row[RIDX_W-1:0];
                end
                if (i_req.char_code == NEWLINE_CODE) begin
                    n_row  = w_row + 1'b1;
                    n_col  = '0;
                    n_cell = w_cell + CELL_W'(COLUMNS) - CELL_W'(w_col);
                end else begin
                    n_cell_write = 1'b1;
                    n_cell_index = w_cell;
                    n_cell_data  = {i_text_attribute, i_req.char_code};
                    n_cell       = w_cell + 1'b1;
                    if (w_col == CIDX_W'(COLUMNS - 1)) begin
                        n_col = '0;
                        n_row = w_row + 1'b1;
                    end else begin
                        n_col = w_col + 1'b1;
                        n_row = w_row;
                    end
                end
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cell      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_cell <= n_cell;
            end
            if (w_advance) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_cell_write <= n_cell_write;
            r_cell_index <= n_cell_index;
            r_cell_data  <= n_cell_data;
            r_clear_row  <= n_clear_row;
            r_clear_idx  <= n_clear_idx;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.cell_write      = r_cell_write;
    assign o_res.cell_index      = r_cell_index;
    assign o_res.cell_data       = r_cell_data;
    assign o_res.clear_row       = r_clear_row;
    assign o_res.clear_row_index = r_clear_idx;
    assign o_res.cursor_after    = r_cell;

    `TCCW_ASSERT_SAME(a_end_is_home_col, i_clk, i_rst_n, r_row == END_ROW, (r_col == '0) && (r_cell == END_CELL))
    `TCCW_ASSERT_NEXT(a_cursor_holds, i_clk, i_rst_n, !w_advance, $stable(r_cell) && $stable(r_row))
    `TCCW_ASSERT_SAME(a_clear_at_row_start, i_clk, i_rst_n, r_res_valid && r_clear_row && r_cell_write, r_cell_index == CELL_W'(r_clear_idx) * CELL_W'(COLUMNS))
endmodule

// ----- rtl/text_console_cursor_writer_core.sv -----
// top level of the text console cursor writer
//
//  channel   dir  handshake          payload
//  i_req     in   valid / ready      req_type, char_code, row_number, column_number
//  o_res     out  valid / ready      cell_write, cell_index, cell_data, clear_row,
//                                    clear_row_index, cursor_after
//  i_cfg     in   valid / ready      data (text attribute byte)
//
// one item per cycle sustained while the result channel is ready; each item passes
// from acceptance through the input register and then the cursor update feeding
// the result register
// the cursor add and compare sits between those two registers
// reset clears the cursor to the home cell and the attribute to 15
// a stalled result holds; the input register still takes one more item behind it
module text_console_cursor_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccw_req_if.sink   i_req,
    tccw_res_if.source o_res,
    tccw_cfg_if.sink   i_cfg
);
    import tccw_pkg::*;

    // field widths follow the grid size
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int CELL_W = $clog2(ROWS * COLUMNS + 1);
    localparam int RIDX_W = $clog2(ROWS);
    localparam int CIDX_W = $clog2(COLUMNS);

    logic [7:0] r_text_attribute;

    // attribute writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attribute <= ATTR_RESET;
        end else if (i_cfg.valid) begin
            r_text_attribute <= i_cfg.data;
        end
    end

    // registered copy of the request channel
    tccw_req_if #(.ROW_W(ROW_W), .COL_W(COL_W)) u_req_q ();

    tccw_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_req   (u_req_q.source)
    );

    // cursor update and result register
    tccw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W),
        .CELL_W  (CELL_W),
        .RIDX_W  (RIDX_W),
        .CIDX_W  (CIDX_W)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_attribute (r_text_attribute),
        .i_req            (u_req_q.sink),
        .o_res            (o_res)
    );
endmodule

// ----- dv/tb.sv -----
// self-checking testbench of the text console cursor writer core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;
    localparam int PHASE_ITEMS  = 240;
    localparam int SQUEEZE_AT   = 120;    // item in each phase where the sender drains first
    localparam int SETTLE_CYC   = 8;      // two-stage pipe plus margin
    localparam int CYCLE_LIMIT  = 400000;

    // one request item as the sender puts it on the channel
    typedef struct packed {
        t_req_type   kind;
        logic [7:0]  ch;
        logic [4:0]  row;
        logic [6:0]  col;
    } console_req_t;

    // one result item, field for field as on the result channel
    typedef struct packed {
        logic        wr;
        logic [10:0] idx;
        logic [15:0] data;
        logic        clr;
        logic [4:0]  clr_idx;
        logic [10:0] cur;
    } console_res_t;

    // directed row: the item, and a typed expectation where chk is set
    typedef struct packed {
        console_req_t req;
        logic         chk;
        console_res_t res;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    tccw_req_if #(.ROW_W(5), .COL_W(7))   req_ch ();
    tccw_res_if #(.CELL_W(11), .RIDX_W(5)) res_ch ();
    tccw_cfg_if                            cfg_ch ();

    text_console_cursor_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // predictor state: our own copy of cursor and attribute
    logic [10:0]  cursor_pos;
    logic [7:0]   text_attr;
    console_res_t cell_expect_q[$];
    int           n_mismatch;
    int           n_results;

    // typed expectation of the item now on the request channel
    logic         drv_chk;
    console_res_t drv_exp;

    // idle shaping: in a calm stretch the side never idles
    bit send_calm;
    bit recv_calm;

    // directed items: extremes, wrap at end of screen, clamping, byte zero
    dir_row_t dir_tab [21] = '{
        // first character after reset lands on the home cell and clears row 0
        '{'{REQ_CHAR,    8'h41, 5'd0,  7'd0  }, 1'b1, '{1'b1, 11'd0,    16'h0F41, 1'b1, 5'd0,  11'd1   }},
        // byte zero is an ordinary character
        '{'{REQ_CHAR,    8'h00, 5'd0,  7'd0  }, 1'b1, '{1'b1, 11'd1,    16'h0F00, 1'b0, 5'd0,  11'd2   }},
        '{'{REQ_CHAR,    8'hFF, 5'd31, 7'd127}, 1'b1, '{1'b1, 11'd2,    16'h0FFF, 1'b0, 5'd0,  11'd3   }},
        // newline mid row, then newline at column 0
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd80  }},
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b1, 5'd1,  11'd160 }},
        // position clamped from below and from above
        '{'{REQ_SET_POS, 8'h00, 5'd0,  7'd0  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd0   }},
        '{'{REQ_SET_POS, 8'hFF, 5'd31, 7'd127}, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd1999}},
        // last cell written, cursor goes to end of screen, next item wraps
        '{'{REQ_CHAR,    8'h7A, 5'd0,  7'd0  }, 1'b1, '{1'b1, 11'd1999, 16'h0F7A, 1'b0, 5'd0,  11'd2000}},
        '{'{REQ_CHAR,    8'h42, 5'd0,  7'd0  }, 1'b1, '{1'b1, 11'd0,    16'h0F42, 1'b1, 5'd0,  11'd1   }},
        // newline on the last row
        '{'{REQ_SET_POS, 8'h00, 5'd25, 7'd1  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd1920}},
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b1, 5'd24, 11'd2000}},
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b1, 5'd0,  11'd80  }},
        '{'{REQ_SET_POS, 8'h00, 5'd26, 7'd81 }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd1999}},
        '{'{REQ_SET_POS, 8'h00, 5'd1,  7'd80 }, 1'b1, '{1'b0, 11'd0,    16'h0000, 1'b0, 5'd0,  11'd79  }},
        '{'{REQ_CHAR,    8'h20, 5'd0,  7'd0  }, 1'b1, '{1'b1, 11'd79,   16'h0F20, 1'b0, 5'd0,  11'd80  }},
        // the rest go through the predictor
        '{'{REQ_SET_POS, 8'h00, 5'd13, 7'd40 }, 1'b0, '0},
        '{'{REQ_CHAR,    8'h55, 5'd7,  7'd3  }, 1'b0, '0},
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b0, '0},
        '{'{REQ_SET_POS, 8'h0A, 5'd25, 7'd80 }, 1'b0, '0},
        '{'{REQ_CHAR,    8'h0A, 5'd0,  7'd0  }, 1'b0, '0},
        '{'{REQ_SET_POS, 8'h00, 5'd0,  7'd127}, 1'b0, '0}
    };

    // works out the result of one item and moves the cursor on
    function automatic console_res_t predict_cell(input console_req_t it);
        console_res_t r;
        int           row_c;
        int           col_c;
        int           cur;
        int           col_pos;
        r   = '0;
        cur = int'(cursor_pos);
        if (it.kind == REQ_SET_POS) begin
            // 1-based target clamped into the grid
            row_c = (it.row < 1) ? 1 : ((it.row > ROWS) ? ROWS : int'(it.row));
            col_c = (it.col < 1) ? 1 : ((it.col > COLUMNS) ? COLUMNS : int'(it.col));
            cur   = (row_c - 1) * COLUMNS + (col_c - 1);
        end else begin
            // end of screen wraps back home before anything else
            if (cur >= SCREEN_CELLS) begin
                cur = 0;
            end
            col_pos = cur % COLUMNS;
            if (col_pos == 0) begin
                r.clr     = 1'b1;
                r.clr_idx = 5'(cur / COLUMNS);
            end
            if (it.ch == NEWLINE_CODE) begin
                cur = cur + COLUMNS - col_pos;
            end else begin
                r.wr   = 1'b1;
                r.idx  = 11'(cur);
                r.data = {text_attr, it.ch};
                cur    = cur + 1;
            end
        end
        cursor_pos = 11'(cur);
        r.cur      = cursor_pos;
        return r;
    endfunction

    // monitor: predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin
        console_res_t got;
        console_res_t want;
        console_req_t seen;
        if (!i_rst_n) begin
            cursor_pos = '0;
            text_attr  = ATTR_RESET;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                text_attr = cfg_ch.data;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.cell_write, res_ch.cell_index, res_ch.cell_data,
                        res_ch.clear_row, res_ch.clear_row_index, res_ch.cursor_after};
                n_results++;
                if (cell_expect_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("tb: result %0d with nothing expected: %p", n_results, got);
                    end
                end else begin
                    want = cell_expect_q.pop_front();
                    if (got.wr !== want.wr || got.idx !== want.idx || got.data !== want.data
                        || got.clr !== want.clr || got.clr_idx !== want.clr_idx
                        || got.cur !== want.cur) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("tb: result %0d mismatch", n_results);
                            $display("    expected wr=%0d idx=%0d data=%h clr=%0d row=%0d cur=%0d",
                                     want.wr, want.idx, want.data, want.clr, want.clr_idx,
                                     want.cur);
                            $display("    actual   wr=%0d idx=%0d data=%h clr=%0d row=%0d cur=%0d",
                                     got.wr, got.idx, got.data, got.clr, got.clr_idx, got.cur);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen = '{t_req_type'(req_ch.req_type), req_ch.char_code,
                         req_ch.row_number, req_ch.column_number};
                want = predict_cell(seen);
                // typed rows override the prediction, the cursor still moves on
                cell_expect_q.push_back(drv_chk ? drv_exp : want);
            end
        end
    end

    // result side: random stall before each item, calm stretches with none
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        recv_calm    = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                recv_calm = !recv_calm;
            end
            stall = recv_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
            @(posedge i_clk);
        end
        $display("tb: FAIL");
        $finish;
    end

    // one request item: optional gap, then hold until accepted; called at a falling edge
    task automatic send_request(input console_req_t it, input logic chk,
                                input console_res_t exp);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type      <= it.kind;
        req_ch.char_code     <= it.ch;
        req_ch.row_number    <= it.row;
        req_ch.column_number <= it.col;
        drv_chk              <= chk;
        drv_exp              <= exp;
        req_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (cell_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // attribute write, only with the pipe empty
    task automatic write_attribute(input logic [7:0] attr);
        drain_results();
        cfg_ch.data  <= attr;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        logic [7:0]   phase_attr [6];
        console_req_t it;
        int           ph;
        int           k;
        int           sel;

        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_CHAR;
        req_ch.char_code     = '0;
        req_ch.row_number    = '0;
        req_ch.column_number = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        drv_chk              = 1'b0;
        drv_exp              = '0;
        send_calm            = 1'b0;
        n_mismatch           = 0;
        n_results            = 0;

        // extremes first, then middling and mixed-bit values
        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'(($urandom_range(1, 254)));
        phase_attr[3] = 8'hA5;
        phase_attr[4] = 8'h5A;
        phase_attr[5] = 8'(($urandom_range(1, 254)));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part under the reset attribute
        for (k = 0; k < $size(dir_tab); k++) begin
            send_request(dir_tab[k].req, dir_tab[k].chk, dir_tab[k].res);
        end

        // random part, one attribute setting per phase
        for (ph = 0; ph < 6; ph++) begin
            write_attribute(phase_attr[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_calm = !send_calm;
                end
                // sender holds off mid phase until the pipe is empty
                if (k == SQUEEZE_AT) begin
                    drain_results();
                end
                sel     = $urandom_range(0, 99);
                it.ch   = 8'($urandom_range(0, 255));
                it.row  = 5'($urandom_range(0, 31));
                it.col  = 7'($urandom_range(0, 127));
                if (sel < 14) begin
                    it.kind = REQ_SET_POS;
                    // mostly in range, often near the bottom so the screen end is reached
                    if ($urandom_range(0, 7) != 0) begin
                        it.row = ($urandom_range(0, 2) == 0) ? 5'd25 : 5'($urandom_range(1, 25));
                        it.col = 7'($urandom_range(1, 80));
                    end
                end else if (sel < 34) begin
                    it.kind = REQ_CHAR;
                    it.ch   = NEWLINE_CODE;
                end else begin
                    it.kind = REQ_CHAR;
                end
                send_request(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (n_mismatch == 0 && cell_expect_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
